/* rtl/upd_pkg.sv */
// Shared types, character codes and helper functions for the URL percent
// decoder with UTF-8 decode. No dependencies.
package upd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_QMARK = 8'h3F;
    localparam logic [7:0] C_ZERO  = 8'd48;
    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_UA    = 8'h41;
    localparam logic [7:0] C_UF    = 8'h46;
    localparam logic [7:0] C_LA    = 8'h61;
    localparam logic [7:0] C_LF    = 8'h66;
    localparam logic [7:0] C_ALPHA_OFS = 8'd7;
    localparam logic [7:0] C_CASE_OFS  = 8'd32;
    localparam logic [5:0] C_CONT_MASK = 6'd63;

    // up to two decoded bytes from one input word, plus the end mark
    typedef struct packed {
        logic [7:0] b0;
        logic       v0;
        logic [7:0] b1;
        logic       v1;
        logic       last;
    } t_entry;

    typedef struct packed {
        logic [2:0] rem;
        logic [1:0] low;
    } t_utf8_st;

    typedef struct packed {
        t_utf8_st   st;
        logic       emit;
        logic [7:0] ch;
    } t_feed;

    function automatic logic is_hex(logic [7:0] c);
        return (c >= C_ZERO && c <= C_NINE) || (c >= C_UA && c <= C_UF) ||
               (c >= C_LA && c <= C_LF);
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [7:0] v;
        v = c - C_ZERO;
        if (c >= C_UA) v = v - C_ALPHA_OFS;
        if (c >= C_LA) v = v - C_CASE_OFS;
        return v[3:0];
    endfunction

    function automatic t_feed utf8_feed(t_utf8_st s, logic [7:0] b);
        t_feed f;
        f.st   = s;
        f.emit = 1'b0;
        f.ch   = 8'h00;
        if (s.rem == 3'd0) begin
            priority if (!b[7]) begin
                f.emit = 1'b1;
                f.ch   = b;
            end else if (b[7:5] == 3'b110) begin
                f.st.rem = 3'd1;
            end else if (b[7:4] == 4'b1110) begin
                f.st.rem = 3'd2;
            end else if (b[7:3] == 5'b11110) begin
                f.st.rem = 3'd3;
            end else if (b[7:2] == 6'b111110) begin
                f.st.rem = 3'd4;
            end else if (b[7:1] == 7'b1111110) begin
                f.st.rem = 3'd5;
            end else begin
                f.emit = 1'b1;
                f.ch   = C_QMARK;
            end
            if (f.st.rem != 3'd0) f.st.low = b[1:0];
        end else begin
            f.st.rem = s.rem - 3'd1;
            if (f.st.rem == 3'd0) begin
                f.emit = 1'b1;
                f.ch   = {s.low, b[5:0] & C_CONT_MASK};
            end else begin
                f.st.low = b[1:0];
            end
        end
        return f;
    endfunction

endpackage

/* rtl/upd_front.sv */
// Front end: percent-escape and '+' decoding of the input words.
// Depends on upd_pkg; feeds upd_fifo.
module upd_front import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_wr,
    output t_entry     o_entry
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HEX  = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_fh, n_fh;
    t_entry     e;
    logic       tail;

    function automatic t_entry add_byte(t_entry x, logic [7:0] b);
        t_entry y;
        y = x;
        if (!x.v0) begin
            y.b0 = b;
            y.v0 = 1'b1;
        end else begin
            y.b1 = b;
            y.v1 = 1'b1;
        end
        return y;
    endfunction

    function automatic logic [7:0] ordinary(logic [7:0] c);
        return (c == C_PLUS) ? C_SPACE : c;
    endfunction

    always_comb begin
        e       = '0;
        n_phase = PH_IDLE;
        n_fh    = r_fh;
        tail    = 1'b1;
        unique case (r_phase)
            PH_PCT: begin
                if (is_hex(i_in_byte)) begin
                    n_fh    = i_in_byte;
                    n_phase = PH_HEX;
                    tail    = 1'b0;
                end
            end
            PH_HEX: begin
                if (is_hex(i_in_byte)) begin
                    e    = add_byte(e, {hex_val(r_fh), hex_val(i_in_byte)});
                    tail = 1'b0;
                end else begin
                    e = add_byte(e, ordinary(r_fh));
                end
            end
            default: begin
            end
        endcase
        if (tail) begin
            if (i_in_byte == C_PCT) n_phase = PH_PCT;
            else e = add_byte(e, ordinary(i_in_byte));
        end
        if (i_end_of_input) begin
            if (n_phase == PH_HEX) e = add_byte(e, ordinary(n_fh));
            n_phase = PH_IDLE;
            n_fh    = 8'h00;
        end
        e.last = i_end_of_input;
    end

    assign o_entry = e;
    assign o_wr    = i_accept && (e.v0 || e.v1 || e.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) r_fh <= n_fh;
    end

endmodule

/* rtl/upd_fifo.sv */
// Short flop queue between the front end and the UTF-8 back end.
// Depends on upd_pkg.
module upd_fifo import upd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_data,
    output logic   o_full,
    input  logic   i_rd,
    output t_entry o_data,
    output logic   o_empty
);

    t_entry         r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (i_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_wr) - (QAW+1)'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

endmodule

/* rtl/upd_back.sv */
// Back end: UTF-8 decode of queued bytes into groups of up to three results,
// handed out one word per pop. Depends on upd_pkg.
module upd_back import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_q,
    input  logic       i_q_empty,
    output logic       o_q_rd,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_output,
    output logic       o_empty,
    input  logic       i_pop
);

    t_utf8_st   r_st, n_st, st_a, st_b;
    t_feed      f0, f1;
    logic       e0, e1;
    logic [7:0] r_gbyte [3];
    logic       r_gvld  [3];
    logic [7:0] n_gbyte [3];
    logic       n_gvld  [3];
    logic [1:0] r_gcnt, r_idx, k;
    logic       r_gvalid, r_glast;
    logic       done, take;

    always_comb begin
        f0   = utf8_feed(r_st, i_q.b0);
        st_a = i_q.v0 ? f0.st : r_st;
        e0   = i_q.v0 && f0.emit;
        f1   = utf8_feed(st_a, i_q.b1);
        st_b = i_q.v1 ? f1.st : st_a;
        e1   = i_q.v1 && f1.emit;

        for (int j = 0; j < 3; j++) begin
            n_gbyte[j] = 8'h00;
            n_gvld[j]  = 1'b1;
        end
        k = 2'd0;
        if (e0) begin
            n_gbyte[k] = f0.ch;
            k = k + 2'd1;
        end
        if (e1) begin
            n_gbyte[k] = f1.ch;
            k = k + 2'd1;
        end
        if (i_q.last) begin
            if (st_b.rem != 3'd0) begin
                n_gbyte[k] = (st_b.rem == 3'd1) ? {st_b.low, 6'd0} : 8'h00;
                k = k + 2'd1;
            end
            if (k == 2'd0) begin
                n_gvld[0] = 1'b0;
                k = 2'd1;
            end
        end
        n_st = i_q.last ? t_utf8_st'('0) : st_b;
    end

    assign done   = r_gvalid && i_pop && (r_idx == r_gcnt - 2'd1);
    assign take   = !i_q_empty && (!r_gvalid || done);
    assign o_q_rd = take;

    assign o_empty         = !r_gvalid;
    assign o_out_byte      = r_gbyte[r_idx];
    assign o_byte_valid    = r_gvld[r_idx];
    assign o_end_of_output = r_glast && (r_idx == r_gcnt - 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= '0;
            r_gvalid <= 1'b0;
            r_idx    <= '0;
            r_gcnt   <= '0;
            r_glast  <= 1'b0;
        end else begin
            if (take) r_st <= n_st;
            if (take && k != 2'd0) begin
                r_gvalid <= 1'b1;
                r_idx    <= '0;
                r_gcnt   <= k;
                r_glast  <= i_q.last;
            end else if (done) begin
                r_gvalid <= 1'b0;
            end else if (r_gvalid && i_pop) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && k != 2'd0) begin
            r_gbyte <= n_gbyte;
            r_gvld  <= n_gvld;
        end
    end

endmodule

/* rtl/url_percent_decode_utf8_to_byte.sv */
// Top level of the URL percent decoder with UTF-8 decode.
// Depends on upd_pkg, upd_front, upd_fifo and upd_back.
//
//  channel   handshake       payload
//  input     push / full     i_in_byte, i_end_of_input
//  result    empty / pop     o_out_byte, o_byte_valid, o_end_of_output
//
// One input word a cycle while the queue has room; the front end sees it in
// the cycle it is taken. A word that decodes to n results (n up to 3) holds
// the result register for n pops; the 4-deep queue absorbs the difference. An
// accepted word passes the queue and then the result register. Reset clears
// the control state only; either side may stall at any time.
module url_percent_decode_utf8_to_byte import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_output
);

    t_entry wr_entry, rd_entry;
    logic   wr, rd, q_empty;

    upd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (push && !full),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_wr           (wr),
        .o_entry        (wr_entry)
    );

    upd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_data  (wr_entry),
        .o_full  (full),
        .i_rd    (rd),
        .o_data  (rd_entry),
        .o_empty (q_empty)
    );

    upd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q             (rd_entry),
        .i_q_empty       (q_empty),
        .o_q_rd          (rd),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_output (o_end_of_output),
        .o_empty         (empty),
        .i_pop           (pop)
    );

endmodule

/* rtl/upd_checker.sv */
// Port-level checks for url_percent_decode_utf8_to_byte, bound to the top.
// Depends on the top level's ports only.
module upd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_end_of_output
);

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_valid |-> o_end_of_output)
        else $error("empty marker not flagged as end of string");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_valid |-> o_out_byte == 8'h00)
        else $error("empty marker carries a byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_byte_valid)
            && $stable(o_end_of_output))
        else $error("result word changed while stalled");

endmodule

bind url_percent_decode_utf8_to_byte upd_checker u_upd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_out_byte      (o_out_byte),
    .o_byte_valid    (o_byte_valid),
    .o_end_of_output (o_end_of_output)
);
